FILE: rtl/core/tdiff_pkg.sv
// tdiff_pkg: shared constants and types of the tracking differentiator
// holds channel count, register codes and the multiply unit request/response types
// no dependencies
`default_nettype none

package tdiff_pkg;

	// number of channels held in the state memory
	localparam int unsigned CHANNELS = 16;
	localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// configuration register indexes and reset values
	localparam logic REG_ACCEL_GAIN   = 1'b0;
	localparam logic REG_DAMPING_GAIN = 1'b1;
	localparam logic [39:0] ACCEL_GAIN_RESET   = 40'd1010640;
	localparam logic [31:0] DAMPING_GAIN_RESET = 32'd11372;

	// rescale codes of the multiply unit (right shift after rounding)
	localparam logic [1:0] SCALE_0  = 2'd0;
	localparam logic [1:0] SCALE_8  = 2'd1;
	localparam logic [1:0] SCALE_24 = 2'd2;
	localparam logic [1:0] SCALE_48 = 2'd3;

	// one channel's stored estimates, signed Q32.16 each
	typedef struct packed {
		logic [47:0] pos;
		logic [47:0] vel;
		logic [47:0] acc;
	} tdiff_entry_t;

	// request to the multiply unit
	typedef struct packed {
		logic        start;
		logic [48:0] x;         // signed operand
		logic [47:0] y;         // unsigned operand
		logic [1:0]  scale;
		logic        wide_lim;  // clamp to 62 bits instead of 48
	} mul_cmd_t;

	// response of the multiply unit
	typedef struct packed {
		logic        done;
		logic [61:0] value;     // signed, rounded and clamped
	} mul_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/tdiff_mul.sv
// tdiff_mul: sequential signed-by-unsigned multiply with round half up and clamp
// one 32x32 multiplier, four partial products into a wide accumulator
// depends on tdiff_pkg
`default_nettype none

module tdiff_mul
	import tdiff_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  mul_cmd_t cmd,
	output mul_rsp_t rsp
);

	logic        busy_q;
	logic [2:0]  step_q;
	logic        pp_vld_s1;
	logic        done_q;
	logic        neg_q;
	logic [48:0] m_q;
	logic [47:0] y_q;
	logic [1:0]  scale_q;
	logic        wide_q;
	logic [97:0] acc_q;
	logic [63:0] pp_s1;
	logic [1:0]  sh_s1;
	logic [61:0] value_q;

	logic [48:0] mag;
	logic [97:0] rnd;
	logic [31:0] limb_a;
	logic [31:0] limb_b;
	logic [63:0] pp_next;
	logic [97:0] addend;
	logic [97:0] shifted;
	logic [97:0] lim_w;
	logic [61:0] mag_sat;
	logic [61:0] value_next;
	logic        finish;

	// magnitude of the operand and rounding offset, folded into the accumulator start
	always_comb begin
		mag = cmd.x[48] ? (49'd0 - cmd.x) : cmd.x;
		case (cmd.scale)
			SCALE_0:  rnd = 98'd0;
			SCALE_8:  rnd = 98'd1 << 7;
			SCALE_24: rnd = 98'd1 << 23;
			SCALE_48: rnd = 98'd1 << 47;
			default:  rnd = 98'd0;
		endcase
		if (cmd.x[48] && cmd.scale != SCALE_0) begin
			rnd = rnd - 98'd1;
		end
	end

	// partial product selection: step bit 1 picks the limb of x, bit 0 the limb of y
	assign limb_a  = step_q[1] ? {15'd0, m_q[48:32]} : m_q[31:0];
	assign limb_b  = step_q[0] ? {16'd0, y_q[47:32]} : y_q[31:0];
	assign pp_next = limb_a * limb_b;

	// alignment of the registered partial product
	always_comb begin
		case (sh_s1)
			2'd0:    addend = 98'(pp_s1);
			2'd1:    addend = 98'(pp_s1) << 32;
			2'd2:    addend = 98'(pp_s1) << 64;
			default: addend = 98'd0;
		endcase
	end

	// rescale, clamp and restore the sign
	always_comb begin
		case (scale_q)
			SCALE_0:  shifted = acc_q;
			SCALE_8:  shifted = acc_q >> 8;
			SCALE_24: shifted = acc_q >> 24;
			SCALE_48: shifted = acc_q >> 48;
			default:  shifted = acc_q;
		endcase
		lim_w = wide_q ? (98'd1 << 61) : (98'd1 << 47);
		if (neg_q) begin
			mag_sat = (shifted > lim_w) ? lim_w[61:0] : shifted[61:0];
		end else begin
			mag_sat = (shifted >= lim_w) ? (lim_w[61:0] - 62'd1) : shifted[61:0];
		end
		value_next = neg_q ? (62'd0 - mag_sat) : mag_sat;
	end

	assign finish = busy_q && step_q[2] && !pp_vld_s1;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= 3'd0;
			pp_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (cmd.start) begin
					busy_q <= 1'b1;
					step_q <= 3'd0;
				end
			end else if (!step_q[2]) begin
				pp_vld_s1 <= 1'b1;
				step_q    <= step_q + 3'd1;
			end else if (pp_vld_s1) begin
				pp_vld_s1 <= 1'b0;
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// operands, partial products and accumulator
	always_ff @(posedge clk) begin
		if (!busy_q && cmd.start) begin
			neg_q   <= cmd.x[48];
			m_q     <= mag;
			y_q     <= cmd.y;
			scale_q <= cmd.scale;
			wide_q  <= cmd.wide_lim;
			acc_q   <= rnd;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + addend;
		end
		if (busy_q && !step_q[2]) begin
			pp_s1 <= pp_next;
			sh_s1 <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
		end
		if (finish) begin
			value_q <= value_next;
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

`default_nettype wire

FILE: rtl/core/tracking_differentiator_unit.sv
// tracking_differentiator_unit: multichannel second-order tracking filter
// state memory with read-modify-write sequencer around the shared multiply unit
// depends on tdiff_pkg and tdiff_mul
//
//   port group   | dir | handshake              | content
//   in_*         | in  | in_valid / in_ready    | channel, sample, time_step
//   out_*        | out | out_valid / out_ready  | channel_out, position_est, velocity_est, accel_est
//   cfg_*        | in  | cfg_write              | cfg_index, cfg_data (gains)
//
// From acceptance until its result is loaded, one request runs six products
// (dt*dt, a*dt*dt, v*dt, a*dt, k1*err, k2*v) in turn through the single 32x32
// multiplier, four partial products apiece.
// A request for a channel out of range goes from acceptance straight to ST_OUT
// and leaves the state alone.
// Reset clears per-channel valid flags at once, so no clearing pass is needed.
// A finished result waits in the output register; a new request is taken meanwhile.
`default_nettype none

module tracking_differentiator_unit
	import tdiff_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [3:0]  channel,
	input  wire  [31:0] sample,
	input  wire  [23:0] time_step,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  channel_out,
	output logic [47:0] position_est,
	output logic [47:0] velocity_est,
	output logic [47:0] accel_est,
	input  wire         cfg_write,
	input  wire         cfg_index,
	input  wire  [39:0] cfg_data
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_ERR  = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	// products in flight
	localparam logic [2:0] JOB_DTSQ = 3'd0;
	localparam logic [2:0] JOB_ADT2 = 3'd1;
	localparam logic [2:0] JOB_VDT  = 3'd2;
	localparam logic [2:0] JOB_ADT  = 3'd3;
	localparam logic [2:0] JOB_ERR  = 3'd4;
	localparam logic [2:0] JOB_DAMP = 3'd5;

	function automatic logic [47:0] sat48(input logic [62:0] v);
		logic ovf;
		ovf = (v[62:47] != {16{1'b0}}) && (v[62:47] != {16{1'b1}});
		if (!ovf) begin
			sat48 = v[47:0];
		end else if (v[62]) begin
			sat48 = {1'b1, 47'd0};
		end else begin
			sat48 = {1'b0, {47{1'b1}}};
		end
	endfunction

	logic [2:0]  state_q;
	logic [2:0]  job_q;
	logic        oor_q;
	logic [39:0] accel_gain_q;
	logic [31:0] damping_gain_q;
	logic [CHANNELS-1:0] valid_q;

	logic [3:0]          ch_q;
	logic [CH_IDX_W-1:0] idx_q;
	logic [31:0] sample_q;
	logic [23:0] dt_q;
	tdiff_entry_t rd_q;
	logic [47:0] p_q, v_q, a_q;
	logic [47:0] t1_q, t2_q, t3_q;
	logic [47:0] np_q, nv_q, na_q;
	logic [61:0] g1_q, g2_q;

	logic        out_valid_q;
	logic [3:0]  channel_out_q;
	logic [47:0] position_est_q, velocity_est_q, accel_est_q;

	tdiff_entry_t mem [CHANNELS];

	mul_cmd_t cmd;
	mul_rsp_t rsp;

	logic        accept;
	logic        in_oor;
	logic        out_free;
	logic        emit;
	logic [49:0] sum_p;
	logic [49:0] sum_v;
	logic [62:0] diff_a;

	assign accept   = in_valid && in_ready;
	assign in_oor   = 32'(channel) >= CHANNELS;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == ST_OUT) && out_free;
	assign in_ready = (state_q == ST_IDLE);

	tdiff_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// requests to the multiply unit; the next product starts on the previous one's done, but k1*err starts from ST_ERR
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.start    = 1'b1;
				cmd.x        = {25'd0, dt_q};
				cmd.y        = {24'd0, dt_q};
				cmd.scale    = SCALE_0;
				cmd.wide_lim = 1'b1;
			end
			ST_MUL: begin
				if (rsp.done) begin
					case (job_q)
						JOB_DTSQ: begin
							cmd.start = 1'b1;
							cmd.x     = {a_q[47], a_q};
							cmd.y     = rsp.value[47:0];
							cmd.scale = SCALE_48;
						end
						JOB_ADT2: begin
							cmd.start = 1'b1;
							cmd.x     = {v_q[47], v_q};
							cmd.y     = {24'd0, dt_q};
							cmd.scale = SCALE_24;
						end
						JOB_VDT: begin
							cmd.start = 1'b1;
							cmd.x     = {a_q[47], a_q};
							cmd.y     = {24'd0, dt_q};
							cmd.scale = SCALE_24;
						end
						JOB_ERR: begin
							cmd.start    = 1'b1;
							cmd.x        = {nv_q[47], nv_q};
							cmd.y        = {16'd0, damping_gain_q};
							cmd.scale    = SCALE_8;
							cmd.wide_lim = 1'b1;
						end
						default: cmd = '0;
					endcase
				end
			end
			ST_ERR: begin
				cmd.start    = 1'b1;
				cmd.x        = {{17{sample_q[31]}}, sample_q} - {np_q[47], np_q};
				cmd.y        = {8'd0, accel_gain_q};
				cmd.scale    = SCALE_8;
				cmd.wide_lim = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	// prediction sums and acceleration difference
	assign sum_p  = {{2{p_q[47]}}, p_q} + {{2{t1_q[47]}}, t1_q} + {{2{t2_q[47]}}, t2_q};
	assign sum_v  = {{2{v_q[47]}}, v_q} + {{2{t3_q[47]}}, t3_q};
	assign diff_a = {g1_q[61], g1_q} - {g2_q[61], g2_q};

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			job_q          <= JOB_DTSQ;
			oor_q          <= 1'b0;
			valid_q        <= '0;
			out_valid_q    <= 1'b0;
			accel_gain_q   <= ACCEL_GAIN_RESET;
			damping_gain_q <= DAMPING_GAIN_RESET;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ACCEL_GAIN:   accel_gain_q   <= cfg_data;
					REG_DAMPING_GAIN: damping_gain_q <= cfg_data[31:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						oor_q   <= in_oor;
						state_q <= in_oor ? ST_OUT : ST_LOAD;
					end
				end
				ST_LOAD: begin
					job_q   <= JOB_DTSQ;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (rsp.done) begin
						case (job_q)
							JOB_DTSQ: job_q <= JOB_ADT2;
							JOB_ADT2: job_q <= JOB_VDT;
							JOB_VDT:  job_q <= JOB_ADT;
							JOB_ADT:  state_q <= ST_SUM;
							JOB_ERR:  job_q <= JOB_DAMP;
							JOB_DAMP: state_q <= ST_ACC;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SUM: state_q <= ST_ERR;
				ST_ERR: begin
					job_q   <= JOB_ERR;
					state_q <= ST_MUL;
				end
				ST_ACC: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!oor_q) begin
							valid_q[idx_q] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// output register
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// state memory: read on acceptance, write back when the result is loaded
	always_ff @(posedge clk) begin
		if (accept && !in_oor) begin
			rd_q <= mem[CH_IDX_W'(channel)];
		end
		if (emit && !oor_q) begin
			mem[idx_q] <= '{pos: np_q, vel: nv_q, acc: na_q};
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= channel;
			idx_q    <= CH_IDX_W'(channel);
			sample_q <= sample;
			dt_q     <= time_step;
		end
		// never-written channels read as zero
		if (state_q == ST_LOAD) begin
			p_q <= valid_q[idx_q] ? rd_q.pos : 48'd0;
			v_q <= valid_q[idx_q] ? rd_q.vel : 48'd0;
			a_q <= valid_q[idx_q] ? rd_q.acc : 48'd0;
		end
		if (state_q == ST_MUL && rsp.done) begin
			case (job_q)
				JOB_ADT2: t2_q <= rsp.value[47:0];
				JOB_VDT:  t1_q <= rsp.value[47:0];
				JOB_ADT:  t3_q <= rsp.value[47:0];
				JOB_ERR:  g1_q <= rsp.value;
				JOB_DAMP: g2_q <= rsp.value;
				default: ;
			endcase
		end
		if (state_q == ST_SUM) begin
			np_q <= sat48({{13{sum_p[49]}}, sum_p});
			nv_q <= sat48({{13{sum_v[49]}}, sum_v});
		end
		if (state_q == ST_ACC) begin
			na_q <= sat48(diff_a);
		end
		if (emit) begin
			channel_out_q  <= ch_q;
			position_est_q <= oor_q ? 48'd0 : np_q;
			velocity_est_q <= oor_q ? 48'd0 : nv_q;
			accel_est_q    <= oor_q ? 48'd0 : na_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign channel_out  = channel_out_q;
	assign position_est = position_est_q;
	assign velocity_est = velocity_est_q;
	assign accel_est    = accel_est_q;

	// one request at a time through the read-modify-write
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while a previous one is still in progress");

	// multiply results only arrive while the sequencer waits for them
	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_MUL))
		else $error("multiply unit finished outside the wait state");

	// a new result appears only from the write-back step
	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result loaded outside write-back");

	// out-of-range channels report zero estimates
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (32'(channel_out) >= CHANNELS)) |->
		(position_est == 48'd0 && velocity_est == 48'd0 && accel_est == 48'd0))
		else $error("out-of-range channel carries non-zero estimates");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// tb_top: self-checking bench for tracking_differentiator_unit
// sends sample requests and gain writes, predicts each channel's estimates in fixed point
// depends on tdiff_pkg and the unit's rtl
module tb_top;
	import tdiff_pkg::*;

	// one channel's new estimates as returned by the unit
	typedef struct packed {
		logic [3:0]  ch;
		logic [47:0] pos;
		logic [47:0] vel;
		logic [47:0] acc;
	} estimate_t;

	// one directed request, with the estimates typed in where they are obvious
	typedef struct packed {
		logic [3:0]  ch;
		logic [31:0] smp;
		logic [23:0] dt;
		bit          known;
		logic [47:0] pos;
		logic [47:0] vel;
		logic [47:0] acc;
	} sample_row_t;

	localparam longint LIM48 = 64'sh0000_8000_0000_0000;
	localparam longint LIM61 = 64'sh2000_0000_0000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  channel = '0;
	logic [31:0] sample = '0;
	logic [23:0] time_step = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  channel_out;
	logic [47:0] position_est;
	logic [47:0] velocity_est;
	logic [47:0] accel_est;
	logic        cfg_write = 1'b0;
	logic        cfg_index = REG_ACCEL_GAIN;
	logic [39:0] cfg_data = '0;

	// filter state and gains as the unit should hold them
	logic [39:0] k1_gain = ACCEL_GAIN_RESET;
	logic [31:0] k2_gain = DAMPING_GAIN_RESET;
	longint      pos_track [CHANNELS] = '{default: 0};
	longint      vel_track [CHANNELS] = '{default: 0};
	longint      acc_track [CHANNELS] = '{default: 0};

	estimate_t   estimates_due [$];
	int unsigned mismatch_count = 0;
	// 0: sender light, receiver heavy; 1: the other way round; 2: no idling
	int unsigned idle_mode = 0;
	int unsigned gap_next = 0;
	bit          valid_held = 1'b0;
	int          last_smp [CHANNELS] = '{default: 0};

	sample_row_t directed_rows [20] = '{
		// reset state: nothing moves
		'{4'd0, 32'h0000_0000, 24'h000000, 1'b1, 48'd0, 48'd0, 48'd0},
		// fresh channel: acceleration is the sample times k1, shifted right by 8
		'{4'd15, 32'h0000_0100, 24'hFF_FFFF, 1'b1, 48'd0, 48'd0, 48'd1010640},
		'{4'd0, 32'h0000_0000, 24'h000000, 1'b1, 48'd0, 48'd0, 48'd0},
		// positive full scale, then repeated longest steps into saturation
		'{4'd1, 32'h7FFF_FFFF, 24'h000000, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd1, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd1, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd1, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0, 48'd0, 48'd0, 48'd0},
		// negative full scale
		'{4'd2, 32'h8000_0000, 24'h000000, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd2, 32'h8000_0000, 24'hFF_FFFF, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd2, 32'h8000_0000, 24'hFF_FFFF, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd2, 32'h8000_0000, 24'hFF_FFFF, 1'b0, 48'd0, 48'd0, 48'd0},
		// slow ramp at a millisecond step
		'{4'd3, 32'h0001_0000, 24'd16777, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd3, 32'h0001_0200, 24'd16777, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd3, 32'h0001_0400, 24'd16777, 1'b0, 48'd0, 48'd0, 48'd0},
		// zero time step, then the smallest one
		'{4'd3, 32'h0001_0600, 24'h000000, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd3, 32'h0001_0600, 24'h000001, 1'b0, 48'd0, 48'd0, 48'd0},
		// alternating bit patterns
		'{4'd4, 32'h5555_5555, 24'h55_5555, 1'b0, 48'd0, 48'd0, 48'd0},
		'{4'd4, 32'hAAAA_AAAA, 24'hAA_AAAA, 1'b0, 48'd0, 48'd0, 48'd0},
		// zero step on a channel at rest: acceleration follows the negative sample
		'{4'd15, 32'hFFFF_FF00, 24'h000000, 1'b1, 48'd0, 48'd0, -48'sd1010640},
		'{4'd15, 32'hFFFF_FF00, 24'hFF_FFFF, 1'b0, 48'd0, 48'd0, 48'd0}
	};

	tracking_differentiator_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.channel      (channel),
		.sample       (sample),
		.time_step    (time_step),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.channel_out  (channel_out),
		.position_est (position_est),
		.velocity_est (velocity_est),
		.accel_est    (accel_est),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// round half up of x*y / 2^s, clamped to [-lim, lim-1]
	function automatic longint rescale_product(longint x, logic [47:0] y, int unsigned s,
			longint lim);
		logic signed [127:0] xw;
		logic signed [127:0] yw;
		logic signed [127:0] prod;
		logic signed [127:0] half;
		xw = x;
		yw = {80'd0, y};
		half = 128'sd1 <<< (s - 1);
		prod = (xw * yw + half) >>> s;
		if (prod > lim - 1)
			return lim - 1;
		if (prod < -lim)
			return -lim;
		return prod[63:0];
	endfunction

	function automatic longint saturate_q48(longint v);
		if (v > LIM48 - 1)
			return LIM48 - 1;
		if (v < -LIM48)
			return -LIM48;
		return v;
	endfunction

	// predict position and velocity, correct acceleration, update the channel
	function automatic estimate_t advance_channel(logic [3:0] ch, logic [31:0] smp,
			logic [23:0] dt);
		estimate_t   e;
		longint      np;
		longint      nv;
		longint      na;
		longint      err;
		logic [47:0] dt_sq;
		e = '0;
		e.ch = ch;
		if (ch >= CHANNELS)
			return e;
		dt_sq = 48'(dt) * 48'(dt);
		np = saturate_q48(pos_track[ch] + rescale_product(vel_track[ch], 48'(dt), 24, LIM48)
			+ rescale_product(acc_track[ch], dt_sq, 48, LIM48));
		nv = saturate_q48(vel_track[ch] + rescale_product(acc_track[ch], 48'(dt), 24, LIM48));
		err = longint'($signed(smp)) - np;
		na = saturate_q48(rescale_product(err, 48'(k1_gain), 8, LIM61)
			- rescale_product(nv, 48'(k2_gain), 8, LIM61));
		pos_track[ch] = np;
		vel_track[ch] = nv;
		acc_track[ch] = na;
		e.pos = np[47:0];
		e.vel = nv[47:0];
		e.acc = na[47:0];
		return e;
	endfunction

	// sender gap before the next request
	function automatic int unsigned pick_gap();
		int unsigned pct;
		pct = (idle_mode == 0) ? 29 : (idle_mode == 1) ? 86 : 0;
		if ($urandom_range(99) >= pct)
			return 0;
		return ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(6, 1);
	endfunction

	task automatic release_input();
		if (valid_held)
			in_valid <= 1'b0;
		valid_held = 1'b0;
	endtask

	// one sample request; valid stays high into a back-to-back request
	task automatic send_sample(logic [3:0] ch, logic [31:0] smp, logic [23:0] dt, bit known,
			estimate_t typed);
		estimate_t e;
		repeat (gap_next) @(posedge clk);
		in_valid <= 1'b1;
		channel <= ch;
		sample <= smp;
		time_step <= dt;
		do @(posedge clk); while (!in_ready);
		e = advance_channel(ch, smp, dt);
		estimates_due.push_back(known ? typed : e);
		valid_held = 1'b1;
		gap_next = pick_gap();
		if (gap_next != 0)
			release_input();
	endtask

	task automatic drain_estimates();
		release_input();
		while (estimates_due.size() != 0)
			@(posedge clk);
	endtask

	// both gains, unit idle; damping gain carries junk above its 32 bits
	task automatic write_gains(logic [39:0] k1, logic [31:0] k2);
		cfg_write <= 1'b1;
		cfg_index <= REG_ACCEL_GAIN;
		cfg_data <= k1;
		@(posedge clk);
		cfg_index <= REG_DAMPING_GAIN;
		cfg_data <= {8'($urandom), k2};
		@(posedge clk);
		cfg_write <= 1'b0;
		k1_gain = k1;
		k2_gain = k2;
	endtask

	// mostly smooth control-loop traffic, some zero steps, noise and full-scale hits
	task automatic send_random_sample();
		logic [3:0]  ch;
		logic [31:0] smp;
		logic [23:0] dt;
		int unsigned pick;
		ch = 4'($urandom);
		pick = $urandom_range(99);
		if (pick < 70) begin
			last_smp[ch] = last_smp[ch] + int'($urandom_range(4000)) - 2000;
			smp = last_smp[ch];
			dt = 24'($urandom_range(200000, 1000));
		end else if (pick < 80) begin
			smp = last_smp[ch];
			dt = '0;
		end else if (pick < 90) begin
			smp = $urandom;
			dt = 24'($urandom);
		end else begin
			smp = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			dt = 24'($urandom);
		end
		send_sample(ch, smp, dt, 1'b0, '0);
	endtask

	task automatic compare_field(string what, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %h got %h", $time, what, want, got);
		end
	endtask

	// receiver: random stalls, check each result against the oldest prediction
	always @(posedge clk) begin : result_sink
		estimate_t   want;
		int unsigned stall_pct;
		stall_pct = (idle_mode == 0) ? 86 : (idle_mode == 1) ? 29 : 0;
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (out_valid && out_ready) begin
			if (estimates_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: result for channel %0d with no request outstanding",
					$time, channel_out);
			end else begin
				want = estimates_due.pop_front();
				compare_field("channel_out", 48'(want.ch), 48'(channel_out));
				compare_field("position_est", want.pos, position_est);
				compare_field("velocity_est", want.vel, velocity_est);
				compare_field("accel_est", want.acc, accel_est);
			end
		end
	end

	// stimulus
	initial begin
		estimate_t typed;
		int unsigned n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			typed = '{directed_rows[i].ch, directed_rows[i].pos, directed_rows[i].vel,
				directed_rows[i].acc};
			send_sample(directed_rows[i].ch, directed_rows[i].smp, directed_rows[i].dt,
				directed_rows[i].known, typed);
		end

		for (int phase = 0; phase < 6; phase++) begin
			drain_estimates();
			idle_mode = phase / 2;
			// reset gains first, then 50 Hz, random, maximum, zero and 1 Hz bandwidth
			case (phase)
				1: write_gains(40'd25266186, 32'd56860);
				2: write_gains(40'({$urandom, $urandom}), $urandom);
				3: write_gains(40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
				4: write_gains(40'd0, 32'd0);
				5: write_gains(40'd10106, 32'd1137);
				default: ;
			endcase
			for (n = 0; n < 115; n++) begin
				// hold off until the unit has returned everything
				if (n == 60)
					drain_estimates();
				send_random_sample();
			end
		end

		drain_estimates();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS tracking_differentiator_unit");
		else
			$display("FAIL tracking_differentiator_unit");
		$finish;
	end

	// run limit
	initial begin
		#(64'd8_000_000);
		$display("FAIL tracking_differentiator_unit");
		$finish;
	end

endmodule
